FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk_i with active-low reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

FILE: src/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and codes of the contiguous block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  // Fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;

  // Request commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_RANGE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE,
    ST_SCAN,
    ST_EVAL,
    ST_FILL,
    ST_DONE
  } state_e;

  // Control of the hole tracker for one cycle
  typedef struct packed {
    logic init;   // restart a search
    logic step;   // one block read back from the bitmap
    logic close;  // end of range reached (best fit)
    logic occ;    // occupancy of the stepped block
    logic best;   // best fit mode
  } scan_ctl_t;

endpackage

`default_nettype wire

FILE: src/contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// Occupancy bitmap allocator with first, best and next fit over runs of
// fixed-size blocks, plus freeing of a given run.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     contents
//  s_axis    in         s_axis_tvalid/s_axis_tready   request transaction
//  m_axis    out        m_axis_tvalid/m_axis_tready   result transaction
//  cfg       in         cfg_valid_i/cfg_ready_o       register write
//
//  After reset the bitmap is cleared one block per cycle with s_axis_tready
//  low (register writes are taken throughout).
//  The bitmap is a single memory with a registered read: scan and free
//  handle one block per cycle. Free reads the run and clears its occupied
//  blocks; allocate scans at most the managed range (a second pass from
//  block 0 for next fit when it wraps), then fills run_length blocks.
//  One request is in flight at a time; a finished result waits in the
//  output register while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module contiguous_block_allocator import cba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request: tuser = command
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [8:0] run_length, [16:9] free_start
  input  wire logic        s_axis_tuser,  // [0] command
  // result
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [7:0] run_start, [16:8] blocks_used
  output logic [1:0]       m_axis_tuser,  // [1:0] status
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_addr_i,
  input  wire logic [8:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned LW = (AW + 1 > 10) ? AW + 1 : 10;

  state_e        state_q, state_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] end_q, end_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] used_q, used_d;
  logic [AW-1:0] anchor_q, anchor_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          pvld_q, pvld_d;
  logic          pass2_q, pass2_d;
  logic [1:0]    status_q, status_d;
  logic [7:0]    start_q, start_d;
  logic [1:0]    policy_q;
  logic [8:0]    range_q;
  logic          out_vld_q, out_vld_d;
  logic [1:0]    out_stat_q, out_stat_d;
  logic [7:0]    out_start_q, out_start_d;
  logic [8:0]    out_used_q, out_used_d;

  // bitmap memory
  logic          mem [NUM_BLOCKS];
  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic [AW-1:0] raddr;
  logic          rdata_q;

  scan_ctl_t     sctl;
  logic          found;
  logic [AW-1:0] pos;

  logic          accept;
  logic          in_cmd;
  logic [LW-1:0] in_len;
  logic [LW-1:0] in_fstart;
  logic [LW-1:0] m_blk;
  logic [LW-1:0] nf_lo;
  logic          issue;
  logic          drained;
  logic          fill_last;
  logic          out_load;
  logic          is_best;
  logic          is_next;
  logic          len_zero;
  logic          free_bad;
  logic          alloc_nofit;

  // Decode the request and the managed range
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign in_cmd      = s_axis_tuser;
  assign in_len      = LW'(s_axis_tdata[8:0]);
  assign in_fstart   = LW'(s_axis_tdata[16:9]);
  assign m_blk       = (LW'(range_q) > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : LW'(range_q);
  assign nf_lo       = LW'(anchor_q) + LW'(1);
  assign is_best     = (policy_q == POL_BEST);
  assign is_next     = (policy_q == POL_NEXT);
  assign len_zero    = (in_len == '0);
  assign free_bad    = (in_fstart + in_len) > m_blk;
  assign alloc_nofit = (in_len > m_blk) ||
                       !((policy_q == POL_FIRST) || is_best || is_next);
  assign issue       = cnt_q < end_q;
  assign drained     = !issue && !pvld_q;
  assign fill_last   = (cnt_q + LW'(1)) == end_q;
  assign out_load    = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LW'(NUM_BLOCKS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (len_zero) begin
            state_d = ST_DONE;
          end else if (in_cmd == CMD_FREE) begin
            state_d = free_bad ? ST_DONE : ST_FREE;
          end else begin
            state_d = alloc_nofit ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_FREE: begin
        if (drained) state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (found && !is_best) begin
          state_d = ST_FILL;
        end else if (drained) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (found) begin
          state_d = ST_FILL;
        end else if (is_next && !pass2_q) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        if (fill_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_d       = cnt_q;
    end_d       = end_q;
    len_d       = len_q;
    used_d      = used_q;
    anchor_d    = anchor_q;
    pidx_d      = cnt_q[AW-1:0];
    pvld_d      = 1'b0;
    pass2_d     = pass2_q;
    status_d    = status_q;
    start_d     = start_q;
    we          = 1'b0;
    waddr       = cnt_q[AW-1:0];
    wdata       = 1'b0;
    raddr       = cnt_q[AW-1:0];
    sctl        = '0;
    sctl.best   = is_best;
    sctl.occ    = rdata_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_start_d = out_start_q;
    out_used_d  = out_used_q;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + LW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          len_d    = in_len;
          status_d = STAT_OK;
          start_d  = '0;
          pass2_d  = 1'b0;
          if (len_zero) begin
            status_d = STAT_BAD;
          end else if (in_cmd == CMD_FREE) begin
            cnt_d = in_fstart;
            end_d = in_fstart + in_len;
            if (free_bad) status_d = STAT_BAD;
          end else if (alloc_nofit) begin
            status_d = STAT_NOFIT;
          end else begin
            sctl.init = 1'b1;
            end_d     = m_blk;
            cnt_d     = '0;
            if (is_next) begin
              if (nf_lo < m_blk) begin
                cnt_d = nf_lo;
              end else begin
                pass2_d = 1'b1;
              end
            end
          end
        end
      end
      ST_FREE: begin
        // Issue reads; clear occupied blocks as they come back
        pvld_d = issue;
        if (issue) cnt_d = cnt_q + LW'(1);
        if (pvld_q && rdata_q) begin
          we    = 1'b1;
          waddr = pidx_q;
          if (used_q != '0) used_d = used_q - LW'(1);
        end
      end
      ST_SCAN: begin
        pvld_d     = issue;
        if (issue) cnt_d = cnt_q + LW'(1);
        sctl.step  = pvld_q;
        sctl.close = drained && is_best;
        if (found && !is_best) begin
          cnt_d = LW'(pos);
          end_d = LW'(pos) + len_q;
        end
      end
      ST_EVAL: begin
        if (found) begin
          cnt_d = LW'(pos);
          end_d = LW'(pos) + len_q;
        end else if (is_next && !pass2_q) begin
          // Wrap to block 0
          pass2_d   = 1'b1;
          sctl.init = 1'b1;
          cnt_d     = '0;
          end_d     = m_blk;
        end else begin
          status_d = STAT_NOFIT;
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        wdata = 1'b1;
        cnt_d = cnt_q + LW'(1);
        if (fill_last) begin
          used_d  = used_q + len_q;
          start_d = 8'(pos);
          if (is_next) anchor_d = pos;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_vld_d   = 1'b1;
          out_stat_d  = status_q;
          out_start_d = start_q;
          out_used_d  = 9'(used_q);
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Hole tracker
  cba_fit_scan #(
    .AW (AW),
    .LW (LW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sctl),
    .idx_i   (pidx_q),
    .len_i   (len_q),
    .found_o (found),
    .pos_o   (pos)
  );

  // Bitmap memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      end_q     <= '0;
      used_q    <= '0;
      anchor_q  <= '0;
      pvld_q    <= 1'b0;
      pass2_q   <= 1'b0;
      out_vld_q <= 1'b0;
      policy_q  <= POL_FIRST;
      range_q   <= 9'd256;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      end_q     <= end_d;
      used_q    <= used_d;
      anchor_q  <= anchor_d;
      pvld_q    <= pvld_d;
      pass2_q   <= pass2_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          REG_POLICY: policy_q <= cfg_data_i[1:0];
          REG_RANGE:  range_q  <= cfg_data_i;
          default:    range_q  <= range_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    pidx_q      <= pidx_d;
    status_q    <= status_d;
    start_q     <= start_d;
    out_stat_q  <= out_stat_d;
    out_start_q <= out_start_d;
    out_used_q  <= out_used_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {7'd0, out_used_q, out_start_q};

  `ASSERT_NEVER(a_used_bound, used_q > LW'(NUM_BLOCKS), "used count above block total")
  `ASSERT_NEVER(a_scan_no_write, we && (state_q == ST_SCAN), "bitmap written during scan")
  `ASSERT_PROP(a_fill_sets, (state_q == ST_FILL) |-> (we && wdata), "fill without write")
  `ASSERT_PROP(a_result_src, $rose(out_vld_q) |-> $past(state_q == ST_DONE),
               "result loaded outside done")

endmodule

`default_nettype wire

FILE: src/cba_fit_scan.sv
// ----------------------------------------------------------------------------
// cba_fit_scan
// Hole tracker: follows the bitmap one block per step and records the hole
// chosen by first fit or best fit.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_fit_scan import cba_pkg::*; #(
  parameter int unsigned AW = 8,
  parameter int unsigned LW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scan_ctl_t     ctl_i,
  input  wire logic [AW-1:0] idx_i,
  input  wire logic [LW-1:0] len_i,
  output logic               found_o,
  output logic [AW-1:0]      pos_o
);

  logic          found_q, found_d;
  logic [LW-1:0] run_q, run_d;
  logic [LW-1:0] best_q, best_d;
  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [LW-1:0] run_inc;
  logic          close_ok;

  assign run_inc  = run_q + LW'(1);
  assign close_ok = (run_q >= len_i) && (!found_q || (run_q <= best_q));

  // Track the current hole and the chosen one
  always_comb begin
    found_d = found_q;
    run_d   = run_q;
    best_d  = best_q;
    start_d = start_q;
    pos_d   = pos_q;
    if (ctl_i.init) begin
      found_d = 1'b0;
      run_d   = '0;
      best_d  = '0;
    end else if (ctl_i.step) begin
      if (ctl_i.best) begin
        if (ctl_i.occ) begin
          if (close_ok) begin
            found_d = 1'b1;
            best_d  = run_q;
            pos_d   = start_q;
          end
          run_d = '0;
        end else begin
          if (run_q == '0) begin
            start_d = idx_i;
          end
          run_d = run_inc;
        end
      end else begin
        if (ctl_i.occ) begin
          run_d = '0;
        end else begin
          run_d = run_inc;
          if (!found_q && (run_inc >= len_i)) begin
            found_d = 1'b1;
            pos_d   = AW'(LW'(idx_i) + LW'(1) - len_i);
          end
        end
      end
    end else if (ctl_i.close && close_ok) begin
      found_d = 1'b1;
      best_d  = run_q;
      pos_d   = start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q   <= run_d;
    best_q  <= best_d;
    start_q <= start_d;
    pos_q   <= pos_d;
  end

  assign found_o = found_q;
  assign pos_o   = pos_q;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contiguous block allocator: random and directed
// allocate/free requests under all fit policies and range settings from 0 to
// 511, checked against a bitmap predictor in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cba_pkg::*;

  localparam int NBLK = 256;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic       cmd;
    logic [8:0] len;
    logic [7:0] fstart;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] start;
    logic [8:0] used;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_addr_i = 1'b0;
  logic [8:0] cfg_data_i = '0;

  contiguous_block_allocator dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic       occ_map [NBLK];
  logic [7:0] anchor;
  int         used_cnt;
  logic [1:0] policy;
  logic [8:0] range_reg;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  int   n_sent = 0;
  int   n_checked = 0;

  bit   calm;              // no idling on either side
  bit   in_taken = 1'b0;   // request transaction accepted at the last rising edge

  function automatic bit find_first(int lo, int hi, int len, output int pos);
    int run;
    run = 0;
    pos = 0;
    for (int i = lo; i < hi; i++) begin
      if (occ_map[i]) begin
        run = 0;
      end else begin
        run++;
        if (run >= len) begin
          pos = i + 1 - len;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit find_best(int hi, int len, output int pos);
    int run, st, best_len;
    bit found;
    run = 0; st = 0; best_len = 0; found = 0; pos = 0;
    for (int i = 0; i <= hi; i++) begin
      if (i == hi || occ_map[i]) begin
        if (run >= len && (!found || run <= best_len)) begin
          found = 1'b1;
          best_len = run;
          pos = st;
        end
        run = 0;
      end else begin
        if (run == 0) st = i;
        run++;
      end
    end
    return found;
  endfunction

  // Apply one request to the predictor and return the result it produces
  function automatic res_t allocate_or_free(req_t r);
    res_t o;
    int m, pos, lo;
    bit found;
    m = (range_reg > NBLK) ? NBLK : range_reg;
    o = '0;
    o.status = STAT_OK;
    pos = 0;
    if (r.len == 0) begin
      o.status = STAT_BAD;
    end else if (r.cmd == CMD_FREE) begin
      if (int'(r.fstart) + int'(r.len) > m) begin
        o.status = STAT_BAD;
      end else begin
        for (int i = r.fstart; i < r.fstart + r.len; i++) begin
          if (occ_map[i]) begin
            occ_map[i] = 1'b0;
            if (used_cnt > 0) used_cnt--;
          end
        end
      end
    end else begin
      found = 1'b0;
      if (r.len <= m) begin
        case (policy)
          POL_FIRST: found = find_first(0, m, r.len, pos);
          POL_BEST:  found = find_best(m, r.len, pos);
          POL_NEXT: begin
            lo = int'(anchor) + 1;
            if (lo < m) found = find_first(lo, m, r.len, pos);
            if (!found) found = find_first(0, m, r.len, pos);
            if (found) anchor = pos[7:0];
          end
          default: found = 1'b0;
        endcase
      end
      if (found) begin
        for (int i = pos; i < pos + r.len; i++) occ_map[i] = 1'b1;
        used_cnt += r.len;
        o.start = pos[7:0];
      end else begin
        o.status = STAT_NOFIT;
      end
    end
    o.used = used_cnt[8:0];
    return o;
  endfunction

  // Driver: present queued requests, idling at random
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
        req_t r;
        r = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {7'd0, r.fstart, r.len};
        expected_results.push_back(allocate_or_free(r));
        n_sent++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 37);
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    cycles++;
    in_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        n_checked++;
        if (m_axis_tuser != e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[7:0] != e.start) begin
          $error("run_start: expected %0d, got %0d", e.start, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[16:8] != e.used) begin
          $error("blocks_used: expected %0d, got %0d", e.used, m_axis_tdata[16:8]);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("contiguous_block_allocator regression: fail");
      $finish;
    end
  end

  // Wait until the queue, the driver's valid and the block have drained
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [8:0] val);
    cfg_addr_i  <= addr;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (addr == REG_POLICY) policy = val[1:0];
    else range_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t mk(logic cmd, int len, int fs);
    req_t r;
    r.cmd = cmd;
    r.len = len[8:0];
    r.fstart = fs[7:0];
    return r;
  endfunction

  // Mostly allocations of short runs, frees of plausible runs, some noise
  task automatic queue_random(int n);
    int k, len;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 3) len = $urandom_range(511);
      else if (k < 8) len = $urandom_range(256, 200);
      else len = $urandom_range(24, 1);
      if (k < 2) len = 0;
      if ($urandom_range(99) < 55)
        pending_reqs.push_back(mk(CMD_ALLOC, len, $urandom_range(255)));
      else
        pending_reqs.push_back(mk(CMD_FREE, (k < 90) ? len : $urandom_range(256),
                                  $urandom_range(255)));
    end
  endtask

  initial begin
    for (int i = 0; i < NBLK; i++) occ_map[i] = 1'b0;
    anchor = '0;
    used_cnt = 0;
    policy = POL_FIRST;
    range_reg = 9'd256;
    calm = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, both commands, zero length, no room, bad free
    pending_reqs.push_back(mk(CMD_ALLOC, 0, 0));
    pending_reqs.push_back(mk(CMD_FREE, 0, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 511, 255));
    pending_reqs.push_back(mk(CMD_ALLOC, 256, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 1, 0));
    pending_reqs.push_back(mk(CMD_FREE, 1, 255));
    pending_reqs.push_back(mk(CMD_FREE, 2, 255));
    pending_reqs.push_back(mk(CMD_FREE, 256, 0));
    pending_reqs.push_back(mk(CMD_FREE, 4, 10));
    pending_reqs.push_back(mk(CMD_ALLOC, 10, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 5, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 20, 0));
    pending_reqs.push_back(mk(CMD_FREE, 5, 0));
    pending_reqs.push_back(mk(CMD_FREE, 3, 12));
    drain();

    // Best fit with equal holes, then next fit wrapping
    write_reg(REG_POLICY, POL_BEST);
    pending_reqs.push_back(mk(CMD_ALLOC, 3, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 2, 170));
    drain();
    write_reg(REG_POLICY, POL_NEXT);
    pending_reqs.push_back(mk(CMD_ALLOC, 200, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 4, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 4, 0));
    drain();

    // Unused policy, empty range, shrunk range
    write_reg(REG_POLICY, 2'd3);
    write_reg(REG_RANGE, 9'd0);
    pending_reqs.push_back(mk(CMD_ALLOC, 1, 0));
    pending_reqs.push_back(mk(CMD_FREE, 1, 0));
    drain();
    write_reg(REG_POLICY, POL_FIRST);
    write_reg(REG_RANGE, 9'd1);
    pending_reqs.push_back(mk(CMD_FREE, 1, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 1, 0));
    pending_reqs.push_back(mk(CMD_ALLOC, 1, 0));
    drain();

    // Random phases over policies and ranges, one phase with no idling
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_POLICY, (ph % 4 == 3) ? 2'($urandom_range(3)) : 2'(ph % 3));
      case (ph % 4)
        0: write_reg(REG_RANGE, 9'd256);
        1: write_reg(REG_RANGE, 9'($urandom_range(64, 8)));
        2: write_reg(REG_RANGE, 9'($urandom_range(511, 257)));
        default: write_reg(REG_RANGE, 9'($urandom_range(256, 1)));
      endcase
      calm = (ph == 5);
      queue_random(50);
      drain();
    end
    calm = 1'b0;

    repeat (600) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked, all policies and ranges 0..511",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("contiguous_block_allocator regression: pass");
    end else begin
      $display("contiguous_block_allocator regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/cba_pkg.sv
src/cba_fit_scan.sv
src/contiguous_block_allocator.sv
dv/tb.sv
